/* src/etd_pkg.sv */
// Shared widths for the trial-division totient core.
package etd_pkg;

	localparam int WIDTH = 32;
	localparam int NW = WIDTH - 1;
	localparam int DW = (NW + 1) / 2 + 1;
	localparam int SW = 2 * DW;
	localparam int OW = 31;
	localparam int CW = $clog2(NW + 1);

endpackage

/* src/euler_totient_trial_division_core.sv */
// Euler totient by trial division over a shared serial divider.
// Sequence: load, then per trial divisor a compare state and a division of
// the remaining number (NW = 31), repeated while the remainder is zero, then
// a final state; the worst case is a prime near 2^31, set by the bit-serial divider.
// Inputs of one or less answer straight from idle. One transaction at a time.
// Reset clears the sequencer and the result strobe; the receiver cannot stall.
module euler_totient_trial_division_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [etd_pkg::WIDTH-1:0]  number,
	output logic                              done,
	output logic [etd_pkg::OW-1:0]            totient
);
	import etd_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_DIVW,
		S_FINAL
	} state_t;

	state_t          state_q;
	logic [NW-1:0]   n_q;
	logic [NW-1:0]   acc_q;
	logic [DW-1:0]   d_q;
	logic [SW-1:0]   sq_q;
	logic            first_q;

	logic            div_start;
	logic [NW-1:0]   div_dividend;
	logic            div_done;
	logic [NW-1:0]   div_quo;
	logic [DW-1:0]   div_rem;
	logic            sq_le;
	logic            trivial;
	logic [NW-1:0]   mul_b;
	logic [2*NW-1:0] product;
	logic [DW-1:0]   factor;

	assign busy = state_q != S_IDLE;
	assign sq_le = sq_q <= {{(SW-NW){1'b0}}, n_q};
	assign trivial = number[WIDTH-1] || (number[WIDTH-2:0] <= NW'(1));

	assign div_start = ((state_q == S_CHECK) && sq_le) ||
		((state_q == S_DIVW) && div_done && (div_rem == '0));
	assign div_dividend = (state_q == S_CHECK) ? n_q : div_quo;

	assign factor = first_q ? (d_q - DW'(1)) : d_q;
	assign mul_b = (state_q == S_FINAL) ? (n_q - NW'(1)) : {{(NW-DW){1'b0}}, factor};
	assign product = acc_q * mul_b;

	etd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (d_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
			totient <= '0;
			n_q <= '0;
			acc_q <= '0;
			d_q <= '0;
			sq_q <= '0;
			first_q <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (trivial) begin
							totient <= OW'(1);
							done <= 1'b1;
						end else begin
							n_q <= number[NW-1:0];
							acc_q <= NW'(1);
							d_q <= DW'(2);
							sq_q <= SW'(4);
							first_q <= 1'b1;
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					state_q <= sq_le ? S_DIVW : S_FINAL;
				end
				S_DIVW: begin
					if (div_done) begin
						if (div_rem == '0) begin
							acc_q <= product[NW-1:0];
							n_q <= div_quo;
							first_q <= 1'b0;
						end else begin
							sq_q <= sq_q + {{(DW-1){1'b0}}, d_q, 1'b1};
							d_q <= d_q + DW'(1);
							first_q <= 1'b1;
							state_q <= S_CHECK;
						end
					end
				end
				S_FINAL: begin
					if (n_q > NW'(1)) begin
						totient <= OW'(product[NW-1:0]);
					end else begin
						totient <= OW'(acc_q);
					end
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/etd_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
module etd_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [etd_pkg::NW-1:0]  dividend,
	input  logic [etd_pkg::DW-1:0]  divisor,
	output logic                    done,
	output logic [etd_pkg::NW-1:0]  quotient,
	output logic [etd_pkg::DW-1:0]  remainder
);
	import etd_pkg::*;

	logic            run_q;
	logic [CW-1:0]   cnt_q;
	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   rem_q;
	logic [DW:0]     shifted;
	logic [DW:0]     diff;
	logic            fits;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign diff = shifted - {1'b0, divisor};
	assign fits = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule
